>>> hw/rtl/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types and constants for the Speck 64/128 encrypt unit.
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 5;

  localparam logic OP_KEY_WRITE = 1'b0;
  localparam logic OP_ENCRYPT   = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] key_index;
    word_t            key_value;
    word_t            block_low;
    word_t            block_high;
  } in_beat_t;

  typedef struct packed {
    word_t cipher_low;
    word_t cipher_high;
  } out_beat_t;

  typedef struct packed {
    logic  valid;
    word_t x;
    word_t y;
  } spk_link_t;

  typedef struct packed {
    logic  we;
    word_t value;
  } spk_key_wr_t;

endpackage

>>> hw/rtl/speck64_128_encrypt_unit.sv
// ----------------------------------------------------------------------------
// speck64_128_encrypt_unit
// Speck 64/128 encryption over a table of round keys held in a row of cells.
//
//   channel | dir | beat
//   in_     | in  | key write (no result) or plaintext block
//   out_    | out | ciphertext block
//
// Key writes may come every cycle while no encrypt block is in flight.
// An encrypt beat walks the row of ROUNDS round cells, one cell per cycle
// while the row is not stalled, and its result is then registered at out_.
// One block is in the row at a time; in_ready is low while it is in flight.
// A held result stalls the row only when the next block reaches its end.
// Reset clears valid state only; round keys are undefined until written.
// ----------------------------------------------------------------------------
module speck64_128_encrypt_unit #(
  parameter int unsigned ROUNDS = 27
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spk_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spk_pkg::out_beat_t out_data
);
  import spk_pkg::*;

  spk_link_t   link [ROUNDS+1];
  spk_key_wr_t key_wr [ROUNDS];
  logic [ROUNDS-1:0] cell_valid;
  logic      busy;
  logic      accept;
  logic      adv;
  logic      out_valid_r;
  out_beat_t out_data_r;

  assign busy     = |cell_valid;
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign adv      = !(link[ROUNDS].valid && out_valid_r && !out_ready);

  assign link[0] = '{valid: accept && (in_data.opcode == OP_ENCRYPT),
                     x: in_data.block_high,
                     y: in_data.block_low};

  for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
    assign key_wr[i] = '{we: accept && (in_data.opcode == OP_KEY_WRITE)
                             && (in_data.key_index == IDX_W'(i)),
                         value: in_data.key_value};
    assign cell_valid[i] = link[i+1].valid;

    spk_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .key_wr   (key_wr[i]),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && link[ROUNDS].valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && link[ROUNDS].valid) begin
      out_data_r <= '{cipher_low: link[ROUNDS].y, cipher_high: link[ROUNDS].x};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/spk_round_cell.sv
// ----------------------------------------------------------------------------
// spk_round_cell
// One Speck round: holds its own round key and passes x/y to the next cell.
// ----------------------------------------------------------------------------
module spk_round_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  spk_pkg::spk_key_wr_t key_wr,
  input  spk_pkg::spk_link_t  link_in,
  output spk_pkg::spk_link_t  link_out
);
  import spk_pkg::*;

  word_t key_r;
  logic  valid_r;
  word_t x_r;
  word_t y_r;
  word_t x_nxt;
  word_t y_nxt;

  always_comb begin
    x_nxt = ({link_in.x[7:0], link_in.x[WORD_W-1:8]} + link_in.y) ^ key_r;
    y_nxt = {link_in.y[WORD_W-4:0], link_in.y[WORD_W-1:WORD_W-3]} ^ x_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_wr.we) begin
      key_r <= key_wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && link_in.valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign link_out = '{valid: valid_r, x: x_r, y: y_r};

endmodule
